// File: sv/dcp_pkg.sv
// Package for the coordinate text parser: character codes, scale factors,
// saturation limits, field step codes and the per-coordinate part record.
// No dependencies.
`default_nettype none

package dcp_pkg;

    localparam int FRAC_DIGITS = 3;

    localparam int MAS_PER_DEG = 3600000;
    localparam int MAS_PER_MIN = 60000;
    localparam int MAS_PER_SEC = 1000;

    localparam int DEG_LIMIT = 360;
    localparam int MIN_LIMIT = 99;
    localparam int SEC_LIMIT = 99;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_W     = 8'h57;

    typedef enum logic [2:0] {
        STEP_SIGN = 3'd0,
        STEP_DEG  = 3'd1,
        STEP_MIN  = 3'd2,
        STEP_SEC  = 3'd3,
        STEP_TAIL = 3'd4
    } step_t;

    typedef struct packed {
        logic       neg;
        logic [8:0] deg;
        logic [6:0] min;
        logic [6:0] sec;
        logic [9:0] frac;
        logic [1:0] fcnt;
    } part_t;

endpackage

`default_nettype wire

// File: sv/dcp_value.sv
// Two-step conversion of one parsed coordinate part to signed
// milliarcseconds: registered partial products, then sum and sign.
// Depends on dcp_pkg.
`default_nettype none

module dcp_value (
    input  wire logic                aclk,
    input  wire logic                load,
    input  wire dcp_pkg::part_t      part_i,
    output logic signed [31:0]       value_o
);
    import dcp_pkg::*;

    logic [9:0]  frac_ms;
    logic [30:0] deg_term_reg;
    logic [22:0] rest_term_reg;
    logic        neg_reg;
    logic [31:0] mag;

    always_comb begin
        unique case (part_i.fcnt)
            2'd0: frac_ms = '0;
            2'd1: frac_ms = 10'(17'(part_i.frac) * 17'd100);
            2'd2: frac_ms = 10'(14'(part_i.frac) * 14'd10);
            2'd3: frac_ms = part_i.frac;
            default: frac_ms = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            deg_term_reg  <= 31'(part_i.deg) * 31'(MAS_PER_DEG);
            rest_term_reg <= 23'(part_i.min) * 23'(MAS_PER_MIN)
                           + 23'(part_i.sec) * 23'(MAS_PER_SEC)
                           + 23'(frac_ms);
            neg_reg       <= part_i.neg;
        end
    end

    assign mag     = 32'(deg_term_reg) + 32'(rest_term_reg);
    assign value_o = neg_reg ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// File: sv/dms_coordinate_parser.sv
// Top level of the coordinate text parser: input register, byte parser,
// result pipeline and output register. Depends on dcp_pkg and dcp_value.
//
// Usage: send the text "lat,lon" one byte per transfer on the s_ channel,
// with s_tlast high on the final byte. Each part is an optional '-', degree
// digits, a separator, minute digits, a separator, seconds with an optional
// decimal fraction, then a hemisphere mark (latitude 'S', longitude 'W' negate).
// One transfer on the m_ channel follows each final byte: latitude and
// longitude in signed milliarcseconds and an error flag (both values zero
// when malformed). Throughput: one byte per cycle while s_tready is high,
// set by the parse stage. A final byte passes the input register, parse
// stage, product register and output register before m_tvalid rises.
// Reset (aresetn low, synchronous) empties all stages and restarts parsing.
// When the receiver stalls, the result holds in the output register and
// bytes keep flowing until a further final byte finds the result stages
// full; s_tready then drops until a slot frees.
`default_nettype none

module dms_coordinate_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // is_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] latitude_mas, [63:32] longitude_mas
    output logic [0:0]       m_tuser    // [0] error_code
);
    import dcp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    logic        phase_reg, phase_next;
    step_t       step_reg, step_next;
    part_t       part_reg, part_next;
    part_t       lat_reg, lat_next;
    logic [1:0]  dot_reg, dot_next;
    logic        digit_reg, digit_next;
    logic        bad_reg, bad_next;
    logic        bad_final;

    logic        fin_valid_reg;
    part_t       fin_lat_reg;
    part_t       fin_lon_reg;
    logic        fin_bad_reg;

    logic        prod_valid_reg;
    logic        prod_bad_reg;
    logic signed [31:0] lat_value;
    logic signed [31:0] lon_value;

    logic        out_valid_reg;
    logic [63:0] out_data_reg;
    logic        out_err_reg;

    logic        adv0, adv1, adv2;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] acc_deg, acc_min, acc_sec;

    assign adv2     = prod_valid_reg && (!out_valid_reg || m_tready);
    assign adv1     = fin_valid_reg && (!prod_valid_reg || adv2);
    assign adv0     = in_valid_reg && (!in_last_reg || !fin_valid_reg || adv1);
    assign s_tready = !in_valid_reg || adv0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    assign is_digit = (in_byte_reg >= CHAR_ZERO) && (in_byte_reg <= CHAR_NINE);
    assign digit    = is_digit ? 4'(in_byte_reg - CHAR_ZERO) : 4'd0;
    assign acc_deg  = 12'(part_reg.deg) * 12'd10 + 12'(digit);
    assign acc_min  = 12'(part_reg.min) * 12'd10 + 12'(digit);
    assign acc_sec  = 12'(part_reg.sec) * 12'd10 + 12'(digit);

    always_comb begin
        phase_next = phase_reg;
        step_next  = step_reg;
        part_next  = part_reg;
        lat_next   = lat_reg;
        dot_next   = dot_reg;
        digit_next = digit_reg;
        bad_next   = bad_reg;
        if (!phase_reg && in_byte_reg == CHAR_COMMA) begin
            if (step_reg != STEP_TAIL) bad_next = 1'b1;
            lat_next   = part_reg;
            part_next  = '0;
            step_next  = STEP_SIGN;
            dot_next   = '0;
            digit_next = 1'b0;
            phase_next = 1'b1;
        end else if (phase_reg && in_byte_reg == CHAR_NUL) begin
            if (step_reg != STEP_TAIL) bad_next = 1'b1;
            step_next = STEP_TAIL;
        end else begin
            unique case (step_reg)
                STEP_SIGN, STEP_DEG: begin
                    if (step_reg == STEP_SIGN && in_byte_reg == CHAR_MINUS) begin
                        part_next.neg = 1'b1;
                        step_next     = STEP_DEG;
                    end else if (is_digit) begin
                        part_next.deg = (acc_deg > 12'(DEG_LIMIT)) ? 9'(DEG_LIMIT)
                                                                  : acc_deg[8:0];
                        digit_next    = 1'b1;
                        step_next     = STEP_DEG;
                    end else begin
                        if (!digit_reg) bad_next = 1'b1;
                        digit_next = 1'b0;
                        step_next  = STEP_MIN;
                    end
                end
                STEP_MIN: begin
                    if (is_digit) begin
                        part_next.min = (acc_min > 12'(MIN_LIMIT)) ? 7'(MIN_LIMIT)
                                                                  : acc_min[6:0];
                        digit_next    = 1'b1;
                    end else begin
                        if (!digit_reg) bad_next = 1'b1;
                        digit_next = 1'b0;
                        step_next  = STEP_SEC;
                    end
                end
                STEP_SEC: begin
                    if (in_byte_reg == CHAR_DOT) begin
                        if (dot_reg < 2'd2) dot_next = dot_reg + 2'd1;
                    end else if (is_digit) begin
                        if (dot_reg == 2'd0) begin
                            part_next.sec = (acc_sec > 12'(SEC_LIMIT)) ? 7'(SEC_LIMIT)
                                                                      : acc_sec[6:0];
                            digit_next    = 1'b1;
                        end else if (dot_reg == 2'd1) begin
                            digit_next = 1'b1;
                            if (32'(part_reg.fcnt) < FRAC_DIGITS) begin
                                part_next.frac = 10'(14'(part_reg.frac) * 14'd10
                                                     + 14'(digit));
                                part_next.fcnt = part_reg.fcnt + 2'd1;
                            end
                        end
                    end else begin
                        if (!digit_reg) bad_next = 1'b1;
                        if ((!phase_reg && in_byte_reg == CHAR_S)
                            || (phase_reg && in_byte_reg == CHAR_W)) begin
                            part_next.neg = 1'b1;
                        end
                        step_next = STEP_TAIL;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign bad_final = bad_next || !phase_next || (step_next != STEP_TAIL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            fin_valid_reg  <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= 1'b0;
            step_reg       <= STEP_SIGN;
            part_reg       <= '0;
            lat_reg        <= '0;
            dot_reg        <= '0;
            digit_reg      <= 1'b0;
            bad_reg        <= 1'b0;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;

            if (adv0 && in_last_reg) fin_valid_reg <= 1'b1;
            else if (adv1)           fin_valid_reg <= 1'b0;

            if (adv1)      prod_valid_reg <= 1'b1;
            else if (adv2) prod_valid_reg <= 1'b0;

            if (adv2)          out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;

            if (adv0) begin
                if (in_last_reg) begin
                    phase_reg <= 1'b0;
                    step_reg  <= STEP_SIGN;
                    part_reg  <= '0;
                    lat_reg   <= '0;
                    dot_reg   <= '0;
                    digit_reg <= 1'b0;
                    bad_reg   <= 1'b0;
                end else begin
                    phase_reg <= phase_next;
                    step_reg  <= step_next;
                    part_reg  <= part_next;
                    lat_reg   <= lat_next;
                    dot_reg   <= dot_next;
                    digit_reg <= digit_next;
                    bad_reg   <= bad_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (adv0 && in_last_reg) begin
            fin_lat_reg <= lat_next;
            fin_lon_reg <= part_next;
            fin_bad_reg <= bad_final;
        end
        if (adv1) prod_bad_reg <= fin_bad_reg;
        if (adv2) begin
            out_data_reg <= prod_bad_reg ? 64'd0 : {lon_value, lat_value};
            out_err_reg  <= prod_bad_reg;
        end
    end

    dcp_value u_lat_value (
        .aclk    (aclk),
        .load    (adv1),
        .part_i  (fin_lat_reg),
        .value_o (lat_value)
    );

    dcp_value u_lon_value (
        .aclk    (aclk),
        .load    (adv1),
        .part_i  (fin_lon_reg),
        .value_o (lon_value)
    );

endmodule

`default_nettype wire
